// ----- sv/eca_pkg.sv -----
package eca_pkg;

	// Default sizes for the top level parameters
	localparam int STAGE_COUNT_DEF = 6;
	localparam int PERIOD_MAX_DEF  = 1024;
	localparam int VALUE_BITS_DEF  = 48;

	// Stage memory slots, fixed by the widest mode
	localparam int STAGE_SLOTS = 6;
	localparam int SLOT_AW     = 3;

	// Fixed-point weights
	localparam int WEIGHT_SHIFT = 24;
	localparam int WEIGHT_W     = 25;
	localparam int COEF_W       = 32;

	// Shared multiplier: operand b is one bit wider than a coefficient
	localparam int MUL_B_W   = COEF_W + 1;
	localparam int MUL_CHUNK = 32;

	// Configuration port
	localparam int PERIOD_W   = 11;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	typedef enum logic [1:0] {
		MODE_EMA,
		MODE_DEMA,
		MODE_TEMA,
		MODE_T3
	} mode_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MODE,
		REG_PERIOD,
		REG_ALPHA,
		REG_INV_PERIOD,
		REG_COEF_C1,
		REG_COEF_C2,
		REG_COEF_C3,
		REG_COEF_C4
	} reg_idx_t;

	// Register reset values
	localparam mode_t                      RST_MODE       = MODE_EMA;
	localparam logic [PERIOD_W-1:0]        RST_PERIOD     = 11'd10;
	localparam logic [WEIGHT_W-1:0]        RST_ALPHA      = 25'd3050402;
	localparam logic [WEIGHT_W-1:0]        RST_INV_PERIOD = 25'd1677722;
	localparam logic signed [COEF_W-1:0]   RST_COEF_C1    = -32'sd5754585;
	localparam logic signed [COEF_W-1:0]   RST_COEF_C2    = 32'sd41926263;
	localparam logic signed [COEF_W-1:0]   RST_COEF_C3    = -32'sd101820924;
	localparam logic signed [COEF_W-1:0]   RST_COEF_C4    = 32'sd82426462;

	// Slot of the last stage a mode needs before its output is defined
	function automatic logic [SLOT_AW-1:0] last_slot(input mode_t m);
		logic [SLOT_AW-1:0] s;
		unique case (m)
			MODE_EMA:  s = SLOT_AW'(0);
			MODE_DEMA: s = SLOT_AW'(1);
			MODE_TEMA: s = SLOT_AW'(2);
			MODE_T3:   s = SLOT_AW'(STAGE_SLOTS - 1);
		endcase
		return s;
	endfunction

endpackage

// ----- sv/eca_mul.sv -----
// Multi-cycle signed multiplier: res = floor(a * b / 2^24).
// Operand a is cut into 32-bit chunks, most significant first; one chunk
// product per cycle, registered, then folded into the exact accumulator.
module eca_mul import eca_pkg::*; #(
	parameter int A_W = 58,
	localparam int NCH = (A_W + MUL_CHUNK - 1) / MUL_CHUNK,
	localparam int RES_W = NCH * MUL_CHUNK + MUL_B_W - WEIGHT_SHIFT
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic signed [A_W-1:0]     a,
	input  logic signed [MUL_B_W-1:0] b,
	output logic                      done,
	output logic signed [RES_W-1:0]   res
);

	localparam int EXT_W  = NCH * MUL_CHUNK;
	localparam int ACC_W  = EXT_W + MUL_B_W;
	localparam int PROD_W = MUL_CHUNK + 1 + MUL_B_W;
	localparam int IDX_W  = (NCH > 1) ? $clog2(NCH) : 1;

	logic signed [EXT_W-1:0]   a_q;
	logic signed [MUL_B_W-1:0] b_q;
	logic [IDX_W-1:0]          idx_q;
	logic                      issue_q;
	logic signed [PROD_W-1:0]  prod_s1;
	logic                      pvld_s1;
	logic                      plast_s1;
	logic signed [ACC_W-1:0]   acc_q;
	logic                      done_q;
	logic [MUL_CHUNK-1:0]      chunk;
	logic signed [MUL_CHUNK:0] chunk_op;

	// Top chunk carries the sign, lower chunks are unsigned
	assign chunk = a_q[idx_q*MUL_CHUNK +: MUL_CHUNK];
	assign chunk_op = (idx_q == IDX_W'(NCH - 1)) ? {chunk[MUL_CHUNK-1], chunk}
	                                              : {1'b0, chunk};

	// Control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			issue_q  <= 1'b0;
			idx_q    <= '0;
			pvld_s1  <= 1'b0;
			plast_s1 <= 1'b0;
			done_q   <= 1'b0;
		end else begin
			if (start) begin
				issue_q <= 1'b1;
				idx_q   <= IDX_W'(NCH - 1);
			end else if (issue_q) begin
				if (idx_q == '0) issue_q <= 1'b0;
				else idx_q <= idx_q - IDX_W'(1);
			end
			pvld_s1  <= issue_q && !start;
			plast_s1 <= issue_q && (idx_q == '0);
			done_q   <= pvld_s1 && plast_s1;
		end
	end

	// Datapath
	always_ff @(posedge clk) begin
		if (start) begin
			a_q   <= EXT_W'(a);
			b_q   <= b;
			acc_q <= '0;
		end else if (pvld_s1) begin
			acc_q <= (acc_q <<< MUL_CHUNK) + ACC_W'(prod_s1);
		end
		if (issue_q) prod_s1 <= chunk_op * b_q;
	end

	assign done = done_q;
	assign res  = acc_q[ACC_W-1:WEIGHT_SHIFT];

endmodule

// ----- sv/ema_cascade_average.sv -----
// Channel   Signals                                   Direction
// cfg       cfg_we, cfg_index, cfg_data               in, write only
// in        in_valid/in_ready: price, missing,        in
//           series_start
// out       out_valid/out_ready: average,             out
//           average_valid
//
// One item at a time. A sample that does not run the cascade goes straight to
// the output. Otherwise each stage multiplies in turn until one is still
// collecting, and T3 adds four coefficient terms through the multiplier.
// Each multiply: stage memory read, two 32-bit partial products
// of the one shared multiplier, accumulate, write-back.
// Reset clears control state and stage valid bits; series_start clears
// them in the accept cycle. A result waiting on out_ready holds only the FSM.
module ema_cascade_average import eca_pkg::*; #(
	parameter int STAGE_COUNT = STAGE_COUNT_DEF,
	parameter int PERIOD_MAX  = PERIOD_MAX_DEF,
	parameter int VALUE_BITS  = VALUE_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [CFG_IDX_W-1:0]         cfg_index,
	input  logic [CFG_DATA_W-1:0]        cfg_data,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic signed [VALUE_BITS-1:0] price,
	input  logic                         missing,
	input  logic                         series_start,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic signed [VALUE_BITS-1:0] average,
	output logic                         average_valid
);

	localparam int CNT_W   = $clog2(PERIOD_MAX + 1);
	localparam int SUM_W   = VALUE_BITS + $clog2(PERIOD_MAX);
	localparam int NCH     = (SUM_W + MUL_CHUNK - 1) / MUL_CHUNK;
	localparam int RES_W   = NCH * MUL_CHUNK + MUL_B_W - WEIGHT_SHIFT;
	localparam int WIDE_W  = RES_W + 2;
	localparam int WORD_W  = CNT_W + SUM_W + VALUE_BITS;
	localparam int T3_TERMS = 4;

	localparam logic signed [WIDE_W-1:0] VMAX_W = WIDE_W'({1'b0, {(VALUE_BITS-1){1'b1}}});
	localparam logic signed [WIDE_W-1:0] VMIN_W = ~VMAX_W;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_STAGE,
		ST_MULW,
		ST_COMBINE,
		ST_T3GO,
		ST_T3W,
		ST_EMIT
	} state_t;

	function automatic logic signed [VALUE_BITS-1:0] sat_val(input logic signed [WIDE_W-1:0] v);
		logic signed [VALUE_BITS-1:0] r;
		if (v > VMAX_W) r = VMAX_W[VALUE_BITS-1:0];
		else if (v < VMIN_W) r = VMIN_W[VALUE_BITS-1:0];
		else r = v[VALUE_BITS-1:0];
		return r;
	endfunction

	// Configuration registers
	mode_t                      mode_q;
	logic [PERIOD_W-1:0]        period_q;
	logic [WEIGHT_W-1:0]        alpha_q;
	logic [WEIGHT_W-1:0]        inv_period_q;
	logic signed [COEF_W-1:0]   coef_q [T3_TERMS];

	// Control
	state_t                     state_q;
	logic [SLOT_AW-1:0]         k_q;
	logic [1:0]                 j_q;
	logic                       started_q;
	logic                       poisoned_q;
	logic                       need_ok_q;
	logic                       res_vld_q;
	logic                       out_valid_q;
	logic signed [VALUE_BITS-1:0] average_q;
	logic                       average_valid_q;

	// Stage memory
	logic [WORD_W-1:0]          stage_mem_q [STAGE_SLOTS];
	logic [STAGE_SLOTS-1:0]     ent_vld_q;
	logic [WORD_W-1:0]          rd_data_s1;
	logic                       rd_vld_s1;
	logic                       rd_en;
	logic [SLOT_AW-1:0]         rd_addr;
	logic                       wr_en;
	logic [WORD_W-1:0]          wr_data;

	// Datapath
	logic signed [VALUE_BITS-1:0] x_q;
	logic [CNT_W-1:0]           w_cnt_q;
	logic signed [SUM_W-1:0]    w_sum_q;
	logic signed [VALUE_BITS-1:0] w_val_q;
	logic                       w_seed_q;
	logic signed [VALUE_BITS-1:0] stage_out_q [STAGE_SLOTS];
	logic signed [WIDE_W-1:0]   t3_acc_q;
	logic signed [VALUE_BITS-1:0] res_q;

	logic                       in_fire;
	logic                       clr;
	logic                       present;
	logic                       st_base, po_base, st_nxt, po_nxt, proc;
	logic [CNT_W-1:0]           p_eff;
	logic [CNT_W-1:0]           r_cnt, n_cnt;
	logic signed [SUM_W-1:0]    r_sum, n_sum, diff;
	logic signed [VALUE_BITS-1:0] r_val;
	logic                       collecting, seeds, brk;
	logic                       last_stage;
	logic [SLOT_AW-1:0]         need_slot;
	logic                       mul_start, mul_done;
	logic signed [SUM_W-1:0]    mul_a;
	logic signed [MUL_B_W-1:0]  mul_b;
	logic signed [RES_W-1:0]    mul_res;
	logic signed [VALUE_BITS-1:0] new_val;
	logic signed [WIDE_W-1:0]   e1, e2, e3, dema, tema, t3_sum;

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q       <= RST_MODE;
			period_q     <= RST_PERIOD;
			alpha_q      <= RST_ALPHA;
			inv_period_q <= RST_INV_PERIOD;
			coef_q[0]    <= RST_COEF_C1;
			coef_q[1]    <= RST_COEF_C2;
			coef_q[2]    <= RST_COEF_C3;
			coef_q[3]    <= RST_COEF_C4;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_index))
				REG_MODE:       mode_q       <= mode_t'(cfg_data[1:0]);
				REG_PERIOD:     period_q     <= cfg_data[PERIOD_W-1:0];
				REG_ALPHA:      alpha_q      <= cfg_data[WEIGHT_W-1:0];
				REG_INV_PERIOD: inv_period_q <= cfg_data[WEIGHT_W-1:0];
				REG_COEF_C1:    coef_q[0]    <= cfg_data;
				REG_COEF_C2:    coef_q[1]    <= cfg_data;
				REG_COEF_C3:    coef_q[2]    <= cfg_data;
				REG_COEF_C4:    coef_q[3]    <= cfg_data;
			endcase
		end
	end

	// Effective period: zero acts as one, clipped at PERIOD_MAX
	always_comb begin
		if (period_q == '0) p_eff = CNT_W'(1);
		else if (32'(period_q) > 32'(PERIOD_MAX)) p_eff = CNT_W'(PERIOD_MAX);
		else p_eff = CNT_W'(period_q);
	end

	// Series flags for the beat being accepted
	assign in_ready = (state_q == ST_IDLE);
	assign in_fire  = in_valid && in_ready;
	assign clr      = in_fire && series_start;
	assign present  = !missing;
	assign st_base  = series_start ? 1'b0 : started_q;
	assign po_base  = series_start ? 1'b0 : poisoned_q;
	assign st_nxt   = st_base || present;
	assign po_nxt   = po_base || (!present && st_base);
	assign proc     = present && st_nxt && !po_nxt;

	// Stage entry as read; an unwritten slot reads as zero
	assign r_val = rd_vld_s1 ? $signed(rd_data_s1[VALUE_BITS-1:0]) : '0;
	assign r_sum = rd_vld_s1 ? $signed(rd_data_s1[VALUE_BITS +: SUM_W]) : '0;
	assign r_cnt = rd_vld_s1 ? rd_data_s1[VALUE_BITS+SUM_W +: CNT_W] : '0;

	// Seed collection or EMA update decision
	assign collecting = (r_cnt < p_eff);
	assign n_cnt      = r_cnt + CNT_W'(1);
	assign n_sum      = r_sum + SUM_W'(x_q);
	assign seeds      = collecting && (n_cnt >= p_eff);
	assign brk        = collecting && !seeds;
	assign diff       = SUM_W'(x_q) - SUM_W'(r_val);

	assign last_stage = (k_q == SLOT_AW'(STAGE_COUNT - 1));
	assign need_slot  = last_slot(mode_q);

	// Multiplier operands
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		if (state_q == ST_STAGE) begin
			if (seeds) begin
				mul_a = n_sum;
				mul_b = $signed({{(MUL_B_W-WEIGHT_W){1'b0}}, inv_period_q});
			end else begin
				mul_a = diff;
				mul_b = $signed({{(MUL_B_W-WEIGHT_W){1'b0}}, alpha_q});
			end
		end else if (state_q == ST_T3GO) begin
			mul_a = SUM_W'(stage_out_q[SLOT_AW'(STAGE_SLOTS - 1) - SLOT_AW'(j_q)]);
			mul_b = MUL_B_W'(coef_q[j_q]);
		end
	end

	assign mul_start = ((state_q == ST_STAGE) && !brk) || (state_q == ST_T3GO);

	eca_mul #(
		.A_W(SUM_W)
	) u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (mul_a),
		.b      (mul_b),
		.done   (mul_done),
		.res    (mul_res)
	);

	// New stage value: seed mean or prev + (x - prev) * alpha
	assign new_val = w_seed_q ? sat_val(WIDE_W'(mul_res))
	                          : sat_val(WIDE_W'(w_val_q) + WIDE_W'(mul_res));

	// Combination terms
	assign e1     = WIDE_W'(stage_out_q[0]);
	assign e2     = WIDE_W'(stage_out_q[1]);
	assign e3     = WIDE_W'(stage_out_q[2]);
	assign dema   = (e1 <<< 1) - e2;
	assign tema   = (e1 <<< 1) + e1 - ((e2 <<< 1) + e2) + e3;
	assign t3_sum = t3_acc_q + WIDE_W'(mul_res);

	// Memory ports
	assign rd_en   = (in_fire && proc) || ((state_q == ST_MULW) && mul_done && !last_stage);
	assign rd_addr = (state_q == ST_IDLE) ? '0 : k_q + SLOT_AW'(1);
	assign wr_en   = ((state_q == ST_STAGE) && brk) || ((state_q == ST_MULW) && mul_done);
	assign wr_data = (state_q == ST_STAGE) ? {n_cnt, n_sum, r_val}
	                                       : {w_cnt_q, w_sum_q, new_val};

	always_ff @(posedge clk) begin
		if (wr_en) stage_mem_q[k_q] <= wr_data;
		if (rd_en) rd_data_s1 <= stage_mem_q[rd_addr];
	end

	// Entry valid bits stand in for clearing the memory
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ent_vld_q <= '0;
			rd_vld_s1 <= 1'b0;
		end else begin
			if (clr) ent_vld_q <= '0;
			else if (wr_en) ent_vld_q[k_q] <= 1'b1;
			if (rd_en) rd_vld_s1 <= ent_vld_q[rd_addr] && !clr;
		end
	end

	// Sequencer and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= ST_IDLE;
			k_q             <= '0;
			j_q             <= '0;
			started_q       <= 1'b0;
			poisoned_q      <= 1'b0;
			need_ok_q       <= 1'b0;
			res_vld_q       <= 1'b0;
			out_valid_q     <= 1'b0;
			average_q       <= '0;
			average_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready) out_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						started_q  <= st_nxt;
						poisoned_q <= po_nxt;
						k_q        <= '0;
						need_ok_q  <= 1'b0;
						res_vld_q  <= 1'b0;
						state_q    <= proc ? ST_STAGE : ST_EMIT;
					end
				end
				ST_STAGE: begin
					state_q <= brk ? ST_COMBINE : ST_MULW;
				end
				ST_MULW: begin
					if (mul_done) begin
						if (k_q == need_slot) need_ok_q <= 1'b1;
						if (last_stage) begin
							state_q <= ST_COMBINE;
						end else begin
							k_q     <= k_q + SLOT_AW'(1);
							state_q <= ST_STAGE;
						end
					end
				end
				ST_COMBINE: begin
					if (need_ok_q && (mode_q == MODE_T3)) begin
						j_q     <= '0;
						state_q <= ST_T3GO;
					end else begin
						res_vld_q <= need_ok_q;
						state_q   <= ST_EMIT;
					end
				end
				ST_T3GO: begin
					state_q <= ST_T3W;
				end
				ST_T3W: begin
					if (mul_done) begin
						if (j_q == 2'(T3_TERMS - 1)) begin
							res_vld_q <= 1'b1;
							state_q   <= ST_EMIT;
						end else begin
							j_q     <= j_q + 2'd1;
							state_q <= ST_T3GO;
						end
					end
				end
				ST_EMIT: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q     <= 1'b1;
						average_q       <= res_q;
						average_valid_q <= res_vld_q;
						state_q         <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Stage working registers and result
	always_ff @(posedge clk) begin
		if (in_fire) begin
			x_q   <= price;
			res_q <= '0;
		end
		if (state_q == ST_STAGE) begin
			w_cnt_q  <= collecting ? n_cnt : r_cnt;
			w_sum_q  <= collecting ? n_sum : r_sum;
			w_val_q  <= r_val;
			w_seed_q <= seeds;
		end
		if ((state_q == ST_MULW) && mul_done) begin
			x_q              <= new_val;
			stage_out_q[k_q] <= new_val;
		end
		if (state_q == ST_COMBINE) begin
			t3_acc_q <= '0;
			if (!need_ok_q) begin
				res_q <= '0;
			end else begin
				unique case (mode_q)
					MODE_EMA:  res_q <= stage_out_q[0];
					MODE_DEMA: res_q <= sat_val(dema);
					MODE_TEMA: res_q <= sat_val(tema);
					MODE_T3:   res_q <= '0;
				endcase
			end
		end
		if ((state_q == ST_T3W) && mul_done) begin
			t3_acc_q <= t3_sum;
			res_q    <= sat_val(t3_sum);
		end
	end

	assign out_valid     = out_valid_q;
	assign average       = average_q;
	assign average_valid = average_valid_q;

	// Checks
	a_clear_on_start: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && series_start |=> ent_vld_q == '0)
		else $error("stage valid bits not cleared by series_start");

	a_mul_expected: assert property (@(posedge clk) disable iff (!arst_n)
		mul_done |-> (state_q == ST_MULW || state_q == ST_T3W))
		else $error("multiplier finished while sequencer not waiting");

	a_poison_started: assert property (@(posedge clk) disable iff (!arst_n)
		poisoned_q |-> started_q)
		else $error("series poisoned before it started");

	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !average_valid |-> average == '0)
		else $error("undefined average not zero");

endmodule
